// ----- sv/mf3_pkg.sv -----
// shared types, register indexes and compare helpers for the 3x3 median filter
// no dependencies
package mf3_pkg;

    localparam int PIX_W = 8;
    localparam int ROW_W = 13;
    localparam int CFG_W = 13;
    localparam int CFG_IDX_W = 1;
    localparam int FW_REG_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [ROW_W-1:0] MIN_DIM    = 13'd3;
    localparam logic [ROW_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [ROW_W-1:0] RST_HEIGHT = 13'd480;
    localparam int RST_WIDTH = 720;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    function automatic pix_t lo8(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t hi8(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t mid3(input pix_t a, input pix_t b, input pix_t c);
        return hi8(lo8(a, b), lo8(hi8(a, b), c));
    endfunction

    // column sort, then median of (max of minima, median of medians, min of maxima)
    function automatic pix_t median9(input win_t w);
        pix_t cmin [3];
        pix_t cmid [3];
        pix_t cmax [3];
        for (int k = 0; k < 3; k++)
        begin
            cmin[k] = lo8(w[0][k], lo8(w[1][k], w[2][k]));
            cmax[k] = hi8(w[0][k], hi8(w[1][k], w[2][k]));
            cmid[k] = mid3(w[0][k], w[1][k], w[2][k]);
        end
        return mid3(hi8(cmin[0], hi8(cmin[1], cmin[2])),
                    mid3(cmid[0], cmid[1], cmid[2]),
                    lo8(cmax[0], lo8(cmax[1], cmax[2])));
    endfunction

endpackage

// ----- sv/mf3_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/median_filter_3x3_top.sv -----
// streaming 3x3 median filter top level: counters, line buffer access, window, output register
// depends on mf3_pkg and mf3_ram
//
// Takes one 8-bit grey pixel word per clock in raster order and returns the
// median-filtered frame in raster order, one word per clock sustained while
// out_stall is low. A result appears for the input word that lies frame_width+1
// words later and is registered through the line buffer read, window shift and
// compare tree stages into the output register. Border rows and columns pass
// through unchanged. After the last pixel of a frame, frame_width+1 words with
// flush set push out the remaining results; frame_last marks the final one. A
// flush word before the frame's pixels are complete is taken and ignored. The
// two previous rows sit in one MAX_WIDTH x 16 line buffer with registered read
// data, read at the column of the incoming word and written back when the word
// moves on; a forwarding path covers the one case where back-to-back words hit
// the same column (the start of the next frame). The line buffer is not cleared
// after reset. Write frame_width and frame_height only while the block is idle;
// a write restarts the frame. Out-of-range values are clamped to [3, MAX_WIDTH]
// and [3, 4096]; frame_width uses only the low 11 bits of cfg_data.
module median_filter_3x3_top
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel_in,
    input  logic                 flush,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 frame_last
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (WCNT_W > CFG_W) ? WCNT_W : CFG_W;
    localparam int RST_W  = (MAX_WIDTH < RST_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int ENT_W  = 2 * PIX_W;

    // clamped frame size
    logic [WCNT_W-1:0] width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [CMP_W-1:0]  cfg_w_ext;

    // input and output positions
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;

    // stage 1: line buffer read in flight
    logic              s1_v_reg;
    logic [COL_W-1:0]  s1_col_reg;
    pix_t              s1_pix_reg;
    logic              s1_emit_reg;
    logic              s1_border_reg;
    logic              s1_last_reg;
    logic              s1_fwd_reg;
    logic [ENT_W-1:0]  s1_fwd_data_reg;

    // stage 2: window updated, median pending
    logic              s2_v_reg;
    logic              s2_emit_reg;
    logic              s2_border_reg;
    logic              s2_last_reg;
    pix_t              s2_bval_reg;

    win_t              win_reg, win_next;

    logic              out_valid_reg;
    pix_t              pixel_out_reg;
    logic              frame_last_reg;

    logic              in_acc, take, flush_phase;
    logic              emit_a, border_a, last_a, col_end, out_col_end, out_row_last;
    pix_t              pix_a;
    logic              s1_adv, s2_adv, s1_ready, out_load;
    logic [ENT_W-1:0]  ram_rd_data, entry;
    pix_t              up_pix, mid_pix;
    logic              fwd_hit;

    // ---------------- handshake and flow ----------------
    assign out_load = s2_v_reg && s2_emit_reg && (!out_valid_reg || !out_stall);
    assign s2_adv   = s2_v_reg && (!s2_emit_reg || !out_valid_reg || !out_stall);
    assign s1_adv   = s1_v_reg && (!s2_v_reg || s2_adv);
    assign s1_ready = !s1_v_reg || s1_adv;
    assign in_stall = !s1_ready;
    assign in_acc   = in_valid && !in_stall;

    // ---------------- stage 0: positions and classification ----------------
    assign flush_phase  = (in_row_reg >= height_reg);
    assign take         = in_acc && !(flush && !flush_phase);
    assign pix_a        = flush_phase ? '0 : pixel_in;
    assign emit_a       = (in_row_reg > ROW_W'(1))
                          || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign col_end      = ((WCNT_W'(in_col_reg) + WCNT_W'(1)) == width_reg);
    assign out_col_end  = ((WCNT_W'(out_col_reg) + WCNT_W'(1)) == width_reg);
    assign out_row_last = (out_row_reg == (height_reg - ROW_W'(1)));
    assign border_a     = (out_row_reg == '0) || out_row_last
                          || (out_col_reg == '0) || out_col_end;
    assign last_a       = out_row_last && out_col_end;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_write)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (take)
        begin
            if (col_end)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit_a)
            begin
                if (last_a)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    assign cfg_w_ext = CMP_W'(cfg_data[FW_REG_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WCNT_W'(RST_W);
            height_reg  <= RST_HEIGHT;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == CFG_FRAME_WIDTH))
            begin
                if (cfg_w_ext < CMP_W'(MIN_DIM))
                    width_reg <= WCNT_W'(MIN_DIM);
                else if (cfg_w_ext > CMP_W'(MAX_WIDTH))
                    width_reg <= WCNT_W'(MAX_WIDTH);
                else
                    width_reg <= WCNT_W'(cfg_w_ext);
            end
            if (cfg_write && (cfg_index == CFG_FRAME_HEIGHT))
            begin
                if (cfg_data < MIN_DIM)
                    height_reg <= MIN_DIM;
                else if (cfg_data > MAX_HEIGHT)
                    height_reg <= MAX_HEIGHT;
                else
                    height_reg <= cfg_data;
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------- line buffer: {upper, middle} per column ----------------
    // a word that enters while the previous one writes the same column takes the write data
    assign fwd_hit = s1_adv && (s1_col_reg == in_col_reg);
    assign entry   = s1_fwd_reg ? s1_fwd_data_reg : ram_rd_data;
    assign up_pix  = entry[ENT_W-1:PIX_W];
    assign mid_pix = entry[PIX_W-1:0];

    mf3_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_pix, s1_pix_reg}),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s1_fwd_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_v_reg   <= take;
            s1_fwd_reg <= take && fwd_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_col_reg      <= in_col_reg;
            s1_pix_reg      <= pix_a;
            s1_emit_reg     <= emit_a;
            s1_border_reg   <= border_a;
            s1_last_reg     <= last_a;
            s1_fwd_data_reg <= {mid_pix, s1_pix_reg};
        end
    end

    // ---------------- stage 1: window shift ----------------
    always_comb
    begin
        win_next = win_reg;
        if (s1_adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[0][2] = up_pix;
            win_next[1][2] = mid_pix;
            win_next[2][2] = s1_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            win_reg <= win_next;
            if (s1_adv)
                s2_v_reg <= 1'b1;
            else if (s2_adv)
                s2_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_emit_reg   <= s1_emit_reg;
            s2_border_reg <= s1_border_reg;
            s2_last_reg   <= s1_last_reg;
            s2_bval_reg   <= win_reg[1][2];
        end
    end

    // ---------------- stage 2: compare tree into output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pixel_out_reg  <= s2_border_reg ? s2_bval_reg : median9(win_reg);
            frame_last_reg <= s2_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;

`ifndef SYNTHESIS
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WCNT_W'(in_col_reg) < width_reg)
        else $error("input column beyond frame width");

    a_out_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_row_reg < height_reg)
        else $error("output row beyond frame height");

    a_forward_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s1_adv && (s1_col_reg == in_col_reg)) |=> s1_fwd_reg)
        else $error("same-column read after write missed forwarding");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("output register loaded while holding a word");

    a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(win_reg))
        else $error("window changed without a word leaving stage 1");
`endif

endmodule
